FILE: rtl/uri_percent_codec_defines.svh
// Assertion helpers used by the codec's top-level RTL.
`ifndef URI_PERCENT_CODEC_DEFINES_SVH
`define URI_PERCENT_CODEC_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define UPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uri_percent_codec: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define UPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uri_percent_codec: next-cycle check failed");

`endif

FILE: rtl/upc_pkg.sv
package upc_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int unsigned MAX_OUT = 3;

  // Decode hold states
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  // Mode register codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Result bytes produced by one request, oldest in slot 0
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    last;
  } group_t;

  // Bytes that stay literal in encode mode
  function automatic logic passes_unescaped(input logic [7:0] c);
    logic ok;
    ok = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
         (c inside {8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h2F, 8'h3A});
    return ok;
  endfunction

  // Hex digit value, bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // Upper-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) begin
      ch = 8'h30 + {4'h0, n};
    end else begin
      ch = 8'h37 + {4'h0, n};
    end
    return ch;
  endfunction

endpackage

FILE: rtl/uri_percent_codec.sv
// The first result byte of a request is valid in the cycle after it is accepted.
// Throughput: one result byte per cycle while result_stall is low; a request loads 1 to 3
// bytes into the output register, and an encoded escape (three bytes) is the largest group.
// A held decode byte yields no result and is not loaded into the output register.
// Reset: mode returns to encode, held decode bytes clear, the output register empties.
`include "uri_percent_codec_defines.svh"

module uri_percent_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       mode
);
  import upc_pkg::*;

  group_t     grp;
  logic       accept;
  logic       load;
  logic       busy;
  logic       mode_q;
  logic [1:0] pending;

  assign cfg_ready  = 1'b1;
  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;
  // Skip loading requests that produce nothing
  assign load       = accept && (grp.cnt != 2'd0);

  upc_xlate u_xlate (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_mode  (mode),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .grp       (grp),
    .mode_q    (mode_q),
    .pending   (pending)
  );

  upc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .grp          (grp),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .busy         (busy)
  );

  `UPC_ASSERT_NOW(a_pending_range, 1'b1, pending != 2'd3)
  `UPC_ASSERT_NEXT(a_encode_no_hold, accept && (mode_q == MODE_ENCODE), pending == PEND_NONE)
  `UPC_ASSERT_NEXT(a_cfg_clears_hold, cfg_valid && cfg_ready, pending == PEND_NONE)
  `UPC_ASSERT_NOW(a_stall_only_busy, item_stall, result_valid)
  `UPC_ASSERT_NEXT(a_last_clears_hold, accept && last_byte, pending == PEND_NONE)

endmodule

FILE: rtl/upc_xlate.sv
module upc_xlate (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_mode,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output upc_pkg::group_t grp,
  output logic            mode_q,
  output logic [1:0]      pending
);
  import upc_pkg::*;

  logic [7:0] held;
  logic [1:0] pending_next;
  logic [7:0] held_next;
  logic [4:0] hv_b;
  logic [4:0] hv_h;
  logic       fresh_emit;

  assign hv_b = hex_value(data_byte);
  assign hv_h = hex_value(held);
  // A fresh percent sign is held unless it ends the string
  assign fresh_emit = !((data_byte == PCT_CHAR) && !last_byte);

  // Build the result group and next hold state
  always_comb begin
    grp          = '0;
    grp.last     = last_byte;
    pending_next = PEND_NONE;
    held_next    = held;
    if (mode_q == MODE_ENCODE) begin
      if (passes_unescaped(data_byte)) begin
        grp.bytes[0] = data_byte;
        grp.cnt      = 2'd1;
      end else begin
        grp.bytes[0] = PCT_CHAR;
        grp.bytes[1] = hex_char(data_byte[7:4]);
        grp.bytes[2] = hex_char(data_byte[3:0]);
        grp.cnt      = 2'd3;
      end
    end else begin
      case (pending)
        PEND_NONE: begin
          grp.bytes[0] = data_byte;
          grp.cnt      = {1'b0, fresh_emit};
          pending_next = fresh_emit ? PEND_NONE : PEND_PCT;
        end
        PEND_PCT: begin
          if (!hv_b[4]) begin
            if (last_byte) begin
              grp.bytes[0] = PCT_CHAR;
              grp.bytes[1] = data_byte;
              grp.cnt      = 2'd2;
            end else begin
              held_next    = data_byte;
              pending_next = PEND_DIGIT;
            end
          end else begin
            grp.bytes[0] = PCT_CHAR;
            grp.bytes[1] = data_byte;
            grp.cnt      = 2'd1 + {1'b0, fresh_emit};
            pending_next = fresh_emit ? PEND_NONE : PEND_PCT;
          end
        end
        PEND_DIGIT: begin
          held_next = '0;
          if (!hv_b[4] && !hv_h[4]) begin
            grp.bytes[0] = {hv_h[3:0], hv_b[3:0]};
            grp.cnt      = 2'd1;
          end else begin
            grp.bytes[0] = PCT_CHAR;
            grp.bytes[1] = held;
            grp.bytes[2] = data_byte;
            grp.cnt      = 2'd2 + {1'b0, fresh_emit};
            pending_next = fresh_emit ? PEND_NONE : PEND_PCT;
          end
        end
        default: begin
          grp.bytes[0] = data_byte;
          grp.cnt      = 2'd1;
        end
      endcase
    end
    // End of string drops anything held
    if (last_byte) begin
      pending_next = PEND_NONE;
      held_next    = '0;
    end
  end

  // Mode and hold state; a mode write clears the hold
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q  <= MODE_ENCODE;
      pending <= PEND_NONE;
      held    <= '0;
    end else if (cfg_we) begin
      mode_q  <= cfg_mode;
      pending <= PEND_NONE;
      held    <= '0;
    end else if (accept) begin
      pending <= pending_next;
      held    <= held_next;
    end
  end

endmodule

FILE: rtl/upc_emit.sv
module upc_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  upc_pkg::group_t grp,
  input  logic            result_stall,
  output logic            result_valid,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            busy
);
  import upc_pkg::*;

  logic [MAX_OUT-1:0][7:0] bytes;
  logic [1:0]              cnt;
  logic [1:0]              idx;
  logic                    last;
  logic                    take;

  assign result_valid = (cnt != 2'd0);
  assign take         = result_valid && !result_stall;
  // Room for a new group once the final byte leaves this cycle
  assign busy         = (cnt > 2'd1) || ((cnt == 2'd1) && result_stall);
  assign out_last     = last && (cnt == 2'd1);

  // Select the byte in front
  always_comb begin
    case (idx)
      2'd0:    out_byte = bytes[0];
      2'd1:    out_byte = bytes[1];
      2'd2:    out_byte = bytes[2];
      default: out_byte = bytes[0];
    endcase
  end

  // Count down the remaining bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= grp.cnt;
      idx <= 2'd0;
    end else if (take) begin
      cnt <= cnt - 2'd1;
      idx <= idx + 2'd1;
    end
  end

  // Hold the group payload
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= grp.bytes;
      last  <= grp.last;
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import upc_pkg::*;

  // One result byte with its end-of-string flag
  typedef struct packed {
    logic [7:0] value;
    logic       fin;
  } coded_byte_t;

  // Track codec state and hold the result bytes still owed by the dut
  class percent_scoreboard;
    logic        cur_mode;
    logic [1:0]  held_cnt;
    logic [7:0]  held_digit;
    logic [7:0]  step_bytes[$];
    coded_byte_t expected_bytes[$];
    int          errors;

    function new();
      cur_mode   = MODE_ENCODE;
      held_cnt   = PEND_NONE;
      held_digit = 8'h00;
      errors     = 0;
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction

    // Append one byte to the results of the current request
    function void add_byte(logic [7:0] b);
      step_bytes = {step_bytes, b};
    endfunction

    // Letters, digits and - _ . ~ / : stay literal when encoding
    function logic is_plain(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h5F ||
             c == 8'h2E || c == 8'h7E || c == 8'h2F || c == 8'h3A;
    endfunction

    // Nibble value of a hex character; bit 4 flags a non-hex byte
    function logic [4:0] hex_val(logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = 5'(c - 8'h37);
      end
      return v;
    endfunction

    function logic [7:0] hex_ch(logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    // Handle a byte in decode mode with nothing held
    function void take_fresh(logic [7:0] b, logic l);
      if (b == PCT_CHAR && !l) begin
        held_cnt = PEND_PCT;
      end else begin
        held_cnt = PEND_NONE;
        add_byte(b);
      end
    endfunction

    // Any mode write drops held decode bytes
    function void set_mode(logic v);
      cur_mode   = v;
      held_cnt   = PEND_NONE;
      held_digit = 8'h00;
    endfunction

    // Work out the result bytes of one accepted request
    function void note_request(logic [7:0] b, logic l);
      logic [4:0]  hi;
      logic [4:0]  lo;
      coded_byte_t e;
      step_bytes.delete();
      lo = hex_val(b);
      if (cur_mode == MODE_ENCODE) begin
        held_cnt = PEND_NONE;
        if (is_plain(b)) begin
          add_byte(b);
        end else begin
          add_byte(PCT_CHAR);
          add_byte(hex_ch(b[7:4]));
          add_byte(hex_ch(b[3:0]));
        end
      end else if (held_cnt == PEND_NONE) begin
        take_fresh(b, l);
      end else if (held_cnt == PEND_PCT) begin
        if (!lo[4]) begin
          if (l) begin
            add_byte(PCT_CHAR);
            add_byte(b);
            held_cnt = PEND_NONE;
          end else begin
            held_digit = b;
            held_cnt   = PEND_DIGIT;
          end
        end else begin
          // broken escape: flush the percent, re-examine this byte
          add_byte(PCT_CHAR);
          take_fresh(b, l);
        end
      end else begin
        hi = hex_val(held_digit);
        if (!hi[4] && !lo[4]) begin
          add_byte({hi[3:0], lo[3:0]});
          held_cnt = PEND_NONE;
        end else begin
          add_byte(PCT_CHAR);
          add_byte(held_digit);
          take_fresh(b, l);
        end
        held_digit = 8'h00;
      end
      if (l) begin
        held_cnt   = PEND_NONE;
        held_digit = 8'h00;
      end
      foreach (step_bytes[i]) begin
        e.value = step_bytes[i];
        e.fin   = l && (i == step_bytes.size() - 1);
        expected_bytes = {expected_bytes, e};
      end
    endfunction

    // Compare one accepted result with the oldest expected byte
    function void check_result(logic [7:0] b, logic l);
      coded_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: no result expected, got 0x%02h (out_last %0b)", b, l);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        if (b !== e.value) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", e.value, b);
          errors++;
        end
        if (l !== e.fin) begin
          $error("out_last: expected %0b, got %0b", e.fin, l);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       mode = MODE_ENCODE;

  bit                idle_on = 1'b1;
  coded_byte_t       stim_plan[$];
  percent_scoreboard sb = new();

  uri_percent_codec dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .mode         (mode)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Check accepted results, then pick the next stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(out_byte, out_last);
    end
    result_stall <= idle_on && ($urandom_range(99) < 6);
  end

  // Queue a literal string, optionally ending it
  function automatic void plan_text(string s, logic end_last);
    coded_byte_t e;
    for (int i = 0; i < s.len(); i++) begin
      e.value = s[i];
      e.fin   = end_last && (i == s.len() - 1);
      stim_plan = {stim_plan, e};
    end
  endfunction

  function automatic void plan_byte(logic [7:0] b, logic l);
    coded_byte_t e;
    e.value = b;
    e.fin   = l;
    stim_plan = {stim_plan, e};
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] n;
    n = 4'($urandom_range(15));
    if (n < 4'd10) begin
      return 8'h30 + n;
    end
    return $urandom_range(1) ? 8'h37 + n : 8'h57 + n;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    logic [4:0] v;
    do begin
      c = 8'($urandom_range(255));
      v = sb.hex_val(c);
    end while (!v[4]);
    return c;
  endfunction

  function automatic void plan_random_encode(int n);
    repeat (n) plan_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
  endfunction

  // Half well-formed escapes, the rest broken ones or raw bytes
  function automatic void plan_random_decode(int n);
    logic [7:0] tok[$];
    int         kind;
    int         cut;
    logic       ends;
    while (stim_plan.size() < n) begin
      tok.delete();
      kind = $urandom_range(9);
      if (kind <= 4) begin
        tok = {PCT_CHAR, rand_hex_char(), rand_hex_char()};
      end else if (kind == 5) begin
        tok = {PCT_CHAR, rand_non_hex()};
      end else if (kind == 6) begin
        tok = {PCT_CHAR, rand_hex_char(), rand_non_hex()};
      end else if (kind == 7) begin
        tok = {PCT_CHAR};
      end else begin
        tok = {8'($urandom_range(255))};
      end
      // end the string here now and then, sometimes inside the escape
      ends = ($urandom_range(5) == 0);
      cut  = ends ? $urandom_range(1, tok.size()) : tok.size();
      for (int i = 0; i < cut; i++) begin
        plan_byte(tok[i], ends && (i == cut - 1));
      end
    end
  endfunction

  task automatic write_mode(logic v);
    cfg_valid <= 1'b1;
    mode      <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mode(v);
    cfg_valid <= 1'b0;
  endtask

  // Offer one request and hold it until accepted
  task automatic send_request(coded_byte_t r);
    if (idle_on && $urandom_range(99) < 6) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte  <= r.value;
    last_byte  <= r.fin;
    do @(posedge clk); while (item_stall);
    sb.note_request(r.value, r.fin);
  endtask

  // Send the planned requests, then wait for every result to arrive
  task automatic run_plan();
    foreach (stim_plan[i]) send_request(stim_plan[i]);
    item_valid <= 1'b0;
    stim_plan.delete();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // encode: byte extremes, every literal class, escaped punctuation
    write_mode(MODE_ENCODE);
    plan_byte(8'h00, 1'b0);
    plan_byte(8'hFF, 1'b0);
    plan_text("Az09-_.~/: %", 1'b1);
    run_plan();

    // decode: good escape, broken escapes, end-of-string flushes
    write_mode(MODE_DECODE);
    plan_text("%4a", 1'b0);
    plan_text("%G", 1'b0);
    plan_text("%4%41", 1'b1);
    plan_text("%4", 1'b1);
    plan_text("%", 1'b1);
    plan_text("%", 1'b0);
    run_plan();

    // random phases; a held percent is dropped by the next mode write
    write_mode(MODE_DECODE);
    plan_random_decode(35);
    run_plan();

    idle_on = 1'b0;
    write_mode(MODE_ENCODE);
    plan_random_encode(35);
    run_plan();
    idle_on = 1'b1;

    write_mode(MODE_DECODE);
    plan_random_decode(40);
    run_plan();

    write_mode(MODE_ENCODE);
    plan_random_encode(30);
    run_plan();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
